// File: hdl/bpc_pkg.sv
// Package for the button press classifier: widths, reset values, codes and the
// structs that pass between the blocks. It depends on nothing else.
package bpc_pkg;

  // Hold counter width. The counters wrap at this width. The range is 12 to 32.
  localparam int CountWidth = 16;
  localparam int LimitWidth = 16;
  localparam int CmpWidth   = (CountWidth > LimitWidth) ? CountWidth : LimitWidth;
  localparam int PinsWidth  = 2;
  localparam int EventWidth = 3;
  localparam int AddrWidth  = 4;
  localparam int DataWidth  = 32;

  localparam logic [LimitWidth-1:0] LongSingleReset = LimitWidth'(3000);
  localparam logic [LimitWidth-1:0] LongBothReset   = LimitWidth'(2000);
  localparam logic [LimitWidth-1:0] ShortLowReset   = LimitWidth'(40);
  localparam logic [LimitWidth-1:0] ShortHighReset  = LimitWidth'(500);

  // Pin patterns. The pins are active low.
  localparam logic [PinsWidth-1:0] PinsBoth    = 2'b00;
  localparam logic [PinsWidth-1:0] PinsTwo     = 2'b01;
  localparam logic [PinsWidth-1:0] PinsOne     = 2'b10;
  localparam logic [PinsWidth-1:0] PinsRelease = 2'b11;

  typedef enum logic [EventWidth-1:0] {
    EvNone      = 3'd0,
    EvShortOne  = 3'd1,
    EvShortTwo  = 3'd2,
    EvShortBoth = 3'd3,
    EvLongOne   = 3'd4,
    EvLongTwo   = 3'd5,
    EvLongBoth  = 3'd6
  } bpc_event_e;

  typedef enum logic [1:0] {
    RegLongSingle = 2'd0,
    RegLongBoth   = 2'd1,
    RegShortLow   = 2'd2,
    RegShortHigh  = 2'd3
  } bpc_reg_e;

  typedef struct packed {
    logic [LimitWidth-1:0] long_single_limit;
    logic [LimitWidth-1:0] long_both_limit;
    logic [LimitWidth-1:0] short_low_limit;
    logic [LimitWidth-1:0] short_high_limit;
  } bpc_cfg_t;

  typedef struct packed {
    logic [PinsWidth-1:0] button_pins;
    logic                 download_active;
    logic                 mode_changed;
  } bpc_item_t;

  typedef struct packed {
    logic [EventWidth-1:0] button_event;
    logic                  clear_mode_changed;
  } bpc_result_t;

endpackage

// File: hdl/bpc_if.sv
// Valid/ready channel interfaces for the button press classifier.
// Depends on bpc_pkg for the field widths.
interface bpc_in_if;
  logic                                valid;
  logic                                ready;
  logic [bpc_pkg::PinsWidth-1:0]       button_pins;
  logic                                download_active;
  logic                                mode_changed;

  modport source (output valid, button_pins, download_active, mode_changed, input ready);
  modport sink   (input valid, button_pins, download_active, mode_changed, output ready);
endinterface

interface bpc_out_if;
  logic                                valid;
  logic                                ready;
  logic [bpc_pkg::EventWidth-1:0]      button_event;
  logic                                clear_mode_changed;

  modport source (output valid, button_event, clear_mode_changed, input ready);
  modport sink   (input valid, button_event, clear_mode_changed, output ready);
endinterface

// File: hdl/button_press_classifier.sv
// Top level of the button press classifier: input register, classifier core,
// result register and APB register file. Depends on bpc_pkg, bpc_if,
// bpc_cfg_regs and bpc_core.
//
// The block classifies presses of two active-low buttons from one pin sample
// per transaction and returns exactly one result transaction for every input
// transaction, in order. It sustains one transaction per clock cycle while
// the output takes its results: a sample is captured in the input register,
// classified by a single pass of compare and increment logic against the
// hold counters, and lands in the result register when it leaves the input
// register. The input side keeps accepting while a result waits, as long as
// the input register is empty or can move into the result register; a
// stalled output backs up at most one sample in the input register before
// ready drops. The four limits are written through the APB port (long single
// at 0x0, long both at 0x4, short low at 0x8, short high at 0xC, low 16 bits
// of the data used) and should only be changed while no transaction is in
// flight. A result carries the event code held after the sample and a
// request flag to clear the external mode-changed flag, set for every release
// sample taken outside a download.
module button_press_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bpc_in_if.sink                        in_i,
  bpc_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::AddrWidth-1:0] paddr,
  input  logic [bpc_pkg::DataWidth-1:0] pwdata,
  output logic [bpc_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  bpc_pkg::bpc_cfg_t    cfg;
  bpc_pkg::bpc_item_t   in_item;
  bpc_pkg::bpc_item_t   s1_item_q;
  bpc_pkg::bpc_result_t core_result;
  bpc_pkg::bpc_result_t res_q;
  logic                 s1_valid_q, s1_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic                 s1_adv;
  logic                 in_fire;

  // The sample in the input register moves on when the result register is
  // empty or its transaction completes in this cycle.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_o.ready);

  assign in_item.button_pins     = in_i.button_pins;
  assign in_item.download_active = in_i.download_active;
  assign in_item.mode_changed    = in_i.mode_changed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item;
    end
    if (s1_adv) begin
      res_q <= core_result;
    end
  end

  bpc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The counters and event code advance exactly once per sample, when it
  // leaves the input register.
  bpc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (core_result)
  );

  assign out_o.valid              = out_valid_q;
  assign out_o.button_event       = res_q.button_event;
  assign out_o.clear_mode_changed = res_q.clear_mode_changed;

endmodule

// File: hdl/bpc_cfg_regs.sv
// APB-style register file holding the four press limits.
// Depends on bpc_pkg for the register codes and the configuration struct.
module bpc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpc_pkg::AddrWidth-1:0]     paddr,
  input  logic [bpc_pkg::DataWidth-1:0]     pwdata,
  output logic [bpc_pkg::DataWidth-1:0]     prdata,
  output logic                              pready,
  output bpc_pkg::bpc_cfg_t                 cfg_o
);

  bpc_pkg::bpc_cfg_t cfg_q, cfg_d;
  bpc_pkg::bpc_reg_e reg_sel;
  logic              wr_en;
  logic [bpc_pkg::LimitWidth-1:0] wdata;
  logic [bpc_pkg::LimitWidth-1:0] rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = bpc_pkg::bpc_reg_e'(paddr[3:2]);
  assign wdata   = pwdata[bpc_pkg::LimitWidth-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        bpc_pkg::RegLongSingle: cfg_d.long_single_limit = wdata;
        bpc_pkg::RegLongBoth:   cfg_d.long_both_limit   = wdata;
        bpc_pkg::RegShortLow:   cfg_d.short_low_limit   = wdata;
        bpc_pkg::RegShortHigh:  cfg_d.short_high_limit  = wdata;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bpc_pkg::RegLongSingle: rdata = cfg_q.long_single_limit;
      bpc_pkg::RegLongBoth:   rdata = cfg_q.long_both_limit;
      bpc_pkg::RegShortLow:   rdata = cfg_q.short_low_limit;
      bpc_pkg::RegShortHigh:  rdata = cfg_q.short_high_limit;
      default:                rdata = '0;
    endcase
  end

  assign prdata = bpc_pkg::DataWidth'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_single_limit <= bpc_pkg::LongSingleReset;
      cfg_q.long_both_limit   <= bpc_pkg::LongBothReset;
      cfg_q.short_low_limit   <= bpc_pkg::ShortLowReset;
      cfg_q.short_high_limit  <= bpc_pkg::ShortHighReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/bpc_core.sv
// Hold counters, held event code and the per-sample classification logic.
// Depends on bpc_pkg for widths, pin patterns, event codes and structs.
module bpc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  bpc_pkg::bpc_item_t    item_i,
  input  bpc_pkg::bpc_cfg_t     cfg_i,
  output bpc_pkg::bpc_result_t  result_o
);

  logic [bpc_pkg::CountWidth-1:0] cnt_one_q, cnt_one_d;
  logic [bpc_pkg::CountWidth-1:0] cnt_two_q, cnt_two_d;
  logic [bpc_pkg::CountWidth-1:0] cnt_both_q, cnt_both_d;
  logic [bpc_pkg::CountWidth-1:0] inc_one, inc_two, inc_both;
  bpc_pkg::bpc_event_e            event_q, event_d;
  logic                           clear_req;
  logic                           short_one, short_two, short_both;
  logic                           long_one, long_two, long_both;

  function automatic logic in_short_window(input logic [bpc_pkg::CountWidth-1:0] cnt,
                                           input bpc_pkg::bpc_cfg_t cfg);
    logic [bpc_pkg::CmpWidth-1:0] c;
    c = bpc_pkg::CmpWidth'(cnt);
    return (c > bpc_pkg::CmpWidth'(cfg.short_low_limit)) &&
           (c < bpc_pkg::CmpWidth'(cfg.short_high_limit));
  endfunction

  assign inc_one  = cnt_one_q + 1'b1;
  assign inc_two  = cnt_two_q + 1'b1;
  assign inc_both = cnt_both_q + 1'b1;

  assign long_one  = bpc_pkg::CmpWidth'(inc_one) > bpc_pkg::CmpWidth'(cfg_i.long_single_limit);
  assign long_two  = bpc_pkg::CmpWidth'(inc_two) > bpc_pkg::CmpWidth'(cfg_i.long_single_limit);
  assign long_both = (bpc_pkg::CmpWidth'(inc_both) > bpc_pkg::CmpWidth'(cfg_i.long_both_limit))
                     && !item_i.mode_changed;

  assign short_one  = in_short_window(cnt_one_q, cfg_i);
  assign short_two  = in_short_window(cnt_two_q, cfg_i);
  assign short_both = in_short_window(cnt_both_q, cfg_i);

  always_comb begin
    cnt_one_d  = cnt_one_q;
    cnt_two_d  = cnt_two_q;
    cnt_both_d = cnt_both_q;
    event_d    = event_q;
    clear_req  = 1'b0;
    // During a download the sample is ignored and the held code is reported.
    if (!item_i.download_active) begin
      unique case (item_i.button_pins)
        bpc_pkg::PinsOne: begin
          cnt_two_d  = '0;
          cnt_both_d = '0;
          cnt_one_d  = long_one ? '0 : inc_one;
          if (long_one) begin
            event_d = bpc_pkg::EvLongOne;
          end
        end
        bpc_pkg::PinsTwo: begin
          cnt_one_d  = '0;
          cnt_both_d = '0;
          cnt_two_d  = long_two ? '0 : inc_two;
          if (long_two) begin
            event_d = bpc_pkg::EvLongTwo;
          end
        end
        bpc_pkg::PinsBoth: begin
          cnt_one_d  = '0;
          cnt_two_d  = '0;
          cnt_both_d = long_both ? '0 : inc_both;
          if (long_both) begin
            event_d = bpc_pkg::EvLongBoth;
          end
        end
        default: begin
          // Release: button one wins over button two, which wins over both.
          cnt_one_d  = '0;
          cnt_two_d  = '0;
          cnt_both_d = '0;
          clear_req  = 1'b1;
          priority if (short_one) begin
            event_d = bpc_pkg::EvShortOne;
          end else if (short_two) begin
            event_d = bpc_pkg::EvShortTwo;
          end else if (short_both) begin
            event_d = bpc_pkg::EvShortBoth;
          end else begin
            event_d = bpc_pkg::EvNone;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_one_q  <= '0;
      cnt_two_q  <= '0;
      cnt_both_q <= '0;
      event_q    <= bpc_pkg::EvNone;
    end else if (step_i) begin
      cnt_one_q  <= cnt_one_d;
      cnt_two_q  <= cnt_two_d;
      cnt_both_q <= cnt_both_d;
      event_q    <= event_d;
    end
  end

  assign result_o.button_event       = event_d;
  assign result_o.clear_mode_changed = clear_req;

endmodule

// File: hdl/bpc_checker.sv
// Port-level checks for the button press classifier and the bind that
// attaches them to the top level. Depends on bpc_pkg and the top level.
module bpc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bpc_pkg::EventWidth-1:0] out_event,
  input logic                           out_clear
);

  // A result waiting to be taken must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_event) && $stable(out_clear))
    else $error("result changed while stalled");

  // With the result register empty the input side always has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input not ready while output is empty");

  // A release never produces a long event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_clear |-> out_event <= bpc_pkg::EvShortBoth)
    else $error("long event reported on a release");

  // Only defined event codes are reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_event <= bpc_pkg::EvLongBoth)
    else $error("undefined event code");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_event (out_o.button_event),
  .out_clear (out_o.clear_mode_changed)
);
